FILE: src/fbcomb_pkg.sv
// Shared types and constants for the feedback comb filter.
package fbcomb_pkg;

    // Parameter defaults
    localparam int DEPTH_DEFAULT    = 8192;
    localparam int SAMPLE_W_DEFAULT = 24;

    // Configuration port
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int DELAY_WHOLE_W  = 13;
    localparam int FRACTION_W     = 16;
    localparam int GAIN_W         = 16;

    localparam logic [DELAY_WHOLE_W-1:0] DELAY_WHOLE_RESET    = 13'd1441;
    localparam logic [FRACTION_W-1:0]    DELAY_FRACTION_RESET = 16'd0;
    localparam logic [GAIN_W-1:0]        FEEDBACK_GAIN_RESET  = 16'd3277;
    localparam logic [GAIN_W-1:0]        GAIN_ONE             = 16'd32768;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DELAY_WHOLE    = 2'd0,
        REG_DELAY_FRACTION = 2'd1,
        REG_FEEDBACK_GAIN  = 2'd2
    } cfg_reg_t;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ2  = 7'b0000100,
        ST_MUL1   = 7'b0001000,
        ST_SUM    = 7'b0010000,
        ST_MUL2   = 7'b0100000,
        ST_COMMIT = 7'b1000000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;  // write zero at the clear counter
        logic accept;    // capture x, read first tap
        logic rd2;       // capture first tap, read second tap
        logic mul1;      // interpolation product
        logic sum;       // interpolated sample
        logic mul2;      // feedback product
        logic commit;    // write back, load output, advance pointer
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } ctrl_status_t;

endpackage

FILE: src/fbcomb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbcomb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/fbcomb_ctrl.sv
// Sequencing state machine for the feedback comb filter.
module fbcomb_ctrl
    import fbcomb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_READ2;
                end
            end
            ST_READ2:  state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_COMMIT;
            ST_COMMIT: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.clear_wr = (state_reg == ST_CLEAR);
        cmd.accept   = (state_reg == ST_IDLE) && s_axis_tvalid;
        cmd.rd2      = (state_reg == ST_READ2);
        cmd.mul1     = (state_reg == ST_MUL1);
        cmd.sum      = (state_reg == ST_SUM);
        cmd.mul2     = (state_reg == ST_MUL2);
        cmd.commit   = (state_reg == ST_COMMIT) && status.out_free;
    end

`ifndef SYNTHESIS
    a_commit_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && !status.out_free) |=> (state_reg == ST_COMMIT))
        else $error("commit left while output register busy");

    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (cmd.rd2 && !s_axis_tready))
        else $error("second tap read did not follow transfer");
`endif

endmodule

FILE: src/fbcomb_dp.sv
// Datapath: config registers, tap addressing, interpolation, feedback and output register.
module fbcomb_dp
    import fbcomb_pkg::*;
#(
    parameter int DELAY_DEPTH  = DEPTH_DEFAULT,
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEFAULT,
    localparam int AW  = $clog2(DELAY_DEPTH),
    localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // config
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    // input payload
    input  logic [TDW-1:0]          s_axis_tdata,
    // result channel
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [TDW-1:0]          m_axis_tdata,
    // control
    input  ctrl_cmd_t               cmd,
    output ctrl_status_t            status,
    // delay memory
    output logic                    ram_we,
    output logic [AW-1:0]           ram_waddr,
    output logic [SAMPLE_WIDTH-1:0] ram_wdata,
    output logic [AW-1:0]           ram_raddr,
    input  logic [SAMPLE_WIDTH-1:0] ram_rdata
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CMPW = ((AW > DELAY_WHOLE_W) ? AW : DELAY_WHOLE_W) + 1;
    localparam logic [CMPW-1:0] DMAX      = CMPW'(DELAY_DEPTH - 2);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(DELAY_DEPTH - 1);
    localparam logic [AW:0]     DEPTH_EXT = (AW + 1)'(DELAY_DEPTH);

    // configuration registers
    logic [DELAY_WHOLE_W-1:0] delay_whole_reg;
    logic [FRACTION_W-1:0]    delay_fraction_reg;
    logic [GAIN_W-1:0]        feedback_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_whole_reg    <= DELAY_WHOLE_RESET;
            delay_fraction_reg <= DELAY_FRACTION_RESET;
            feedback_gain_reg  <= FEEDBACK_GAIN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DELAY_WHOLE:    delay_whole_reg    <= cfg_wdata[DELAY_WHOLE_W-1:0];
                REG_DELAY_FRACTION: delay_fraction_reg <= cfg_wdata[FRACTION_W-1:0];
                REG_FEEDBACK_GAIN:  feedback_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // control registers
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          m_valid_reg, m_valid_next;

    // payload registers
    logic [AW-1:0]              a1_reg;
    logic signed [SW-1:0]       x_reg;
    logic signed [SW-1:0]       s1_reg;
    logic signed [SW+17:0]      prod_reg;
    logic signed [SW-1:0]       y_reg;
    logic signed [SW+16:0]      fbp_reg;
    logic [SW-1:0]              out_data_reg;

    // delay clamp and tap addresses
    logic [CMPW-1:0] dw_ext;
    logic [AW-1:0]   d_clamp;
    logic [AW-1:0]   a1;
    logic [AW-1:0]   a2;
    logic [AW:0]     a1_wrap;

    always_comb begin
        dw_ext = CMPW'(delay_whole_reg);
        if (dw_ext == '0) begin
            d_clamp = AW'(1);
        end else if (dw_ext > DMAX) begin
            d_clamp = DMAX[AW-1:0];
        end else begin
            d_clamp = dw_ext[AW-1:0];
        end
        a1_wrap = {1'b0, wp_reg} + DEPTH_EXT - {1'b0, d_clamp};
        if (wp_reg >= d_clamp) begin
            a1 = wp_reg - d_clamp;
        end else begin
            a1 = a1_wrap[AW-1:0];
        end
        a2 = (a1_reg == '0) ? LAST_ADDR : a1_reg - 1'b1;
    end

    // arithmetic
    logic signed [SW-1:0]   s2;
    logic signed [SW:0]     diff;
    logic signed [16:0]     frac_s;
    logic signed [SW+17:0]  prod_next;
    logic signed [SW+17:0]  prod_sh;
    logic [SW+1:0]          y_sum;
    logic [GAIN_W-1:0]      g_clamp;
    logic signed [16:0]     g_s;
    logic signed [SW+16:0]  fbp_next;
    logic signed [SW+16:0]  fbp_sh;
    logic signed [SW:0]     w_sum;
    logic [SW-1:0]          w;

    always_comb begin
        s2        = ram_rdata;
        diff      = {s2[SW-1], s2} - {s1_reg[SW-1], s1_reg};
        frac_s    = {1'b0, delay_fraction_reg};
        prod_next = diff * frac_s;
        // arithmetic shift floors toward minus infinity
        prod_sh   = prod_reg >>> 16;
        y_sum     = {{2{s1_reg[SW-1]}}, s1_reg} + prod_sh[SW+1:0];
        g_clamp   = (feedback_gain_reg > GAIN_ONE) ? GAIN_ONE : feedback_gain_reg;
        g_s       = {1'b0, g_clamp};
        fbp_next  = y_reg * g_s;
        fbp_sh    = fbp_reg >>> 15;
        w_sum     = {x_reg[SW-1], x_reg} + fbp_sh[SW:0];
        if (w_sum[SW] != w_sum[SW-1]) begin
            w = w_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            w = w_sum[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            x_reg  <= s_axis_tdata[SW-1:0];
            a1_reg <= a1;
        end
        if (cmd.rd2) begin
            s1_reg <= ram_rdata;
        end
        if (cmd.mul1) begin
            prod_reg <= prod_next;
        end
        if (cmd.sum) begin
            y_reg <= y_sum[SW-1:0];
        end
        if (cmd.mul2) begin
            fbp_reg <= fbp_next;
        end
        if (cmd.commit) begin
            out_data_reg <= y_reg;
        end
    end

    always_comb begin
        clr_cnt_next = cmd.clear_wr ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        wp_next      = wp_reg;
        if (cmd.commit) begin
            wp_next = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            wp_reg      <= wp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign status.clear_last = (clr_cnt_reg == LAST_ADDR);
    assign status.out_free   = !m_valid_reg || m_axis_tready;

    assign ram_we    = cmd.clear_wr || cmd.commit;
    assign ram_waddr = cmd.clear_wr ? clr_cnt_reg : wp_reg;
    assign ram_wdata = cmd.clear_wr ? '0 : w;
    assign ram_raddr = cmd.rd2 ? a2 : a1;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TDW'(out_data_reg);

`ifndef SYNTHESIS
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("result transfer not offered after commit");

    a_wp_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (wp_reg == (($past(wp_reg) == LAST_ADDR) ? AW'(0)
                                   : AW'($past(wp_reg) + 1'b1))))
        else $error("write pointer did not advance around the ring");

    a_wp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.commit |=> $stable(wp_reg))
        else $error("write pointer moved without a commit");
`endif

endmodule

FILE: src/feedback_comb_filter.sv
// Feedback comb filter with linearly interpolated fractional delay.
// A sample runs ST_READ2, ST_MUL1, ST_SUM, ST_MUL2, then ST_COMMIT loads the
// output register once free. Only then is the next sample taken, due to the
// single delay-memory read port (two taps read one after the other) and the
// two registered multiply steps. A synchronous active-low reset is followed
// by a pass zeroing DELAY_DEPTH words (8192 by default), s_axis_tready low.
module feedback_comb_filter
    import fbcomb_pkg::*;
#(
    parameter int DELAY_DEPTH  = DEPTH_DEFAULT,
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEFAULT,
    localparam int AW  = $clog2(DELAY_DEPTH),
    localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDW-1:0]         s_axis_tdata,   // audio_in
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDW-1:0]         m_axis_tdata    // audio_out
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [SAMPLE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [SAMPLE_WIDTH-1:0] ram_rdata;

    fbcomb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    fbcomb_dp #(
        .DELAY_DEPTH  (DELAY_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    fbcomb_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the feedback comb filter: directed table, then randomized phases.
module tb_top;
    import fbcomb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int SW    = SAMPLE_W_DEFAULT;
    localparam int TDW   = ((SW + 7) / 8) * 8;
    localparam int RAW   = $clog2(DEPTH);

    localparam int RANDOM_ITEMS = 650;

    localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] NEG1 = {SW{1'b1}};

    // index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        ROW_FEED,        // sample, expectation from the predictor
        ROW_FEED_KNOWN,  // sample, expectation typed in
        ROW_WRITE        // register write
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
        logic [SW-1:0]          sample;
        logic [SW-1:0]          want;
    } dir_row_t;

    localparam int N_ROWS = 33;

    localparam dir_row_t DIRECTED [N_ROWS] = '{
        // reset delay reads cleared memory
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     SMAX,        24'd0},
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     SMIN,        24'd0},
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     24'd1,       24'd0},
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     NEG1,        24'd0},
        // one-sample delay, no feedback: y is the previous x
        '{ROW_WRITE,      REG_DELAY_WHOLE,    16'd1,     24'd0,       24'd0},
        '{ROW_WRITE,      REG_FEEDBACK_GAIN,  16'd0,     24'd0,       24'd0},
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     24'd0,       NEG1},
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     SMAX,        24'd0},
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     SMIN,        SMAX},
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     24'd5,       SMIN},
        // zero delay behaves as one
        '{ROW_WRITE,      REG_DELAY_WHOLE,    16'd0,     24'd0,       24'd0},
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     24'd7,       24'd5},
        // upper bits dropped, 8191 clamps to depth-2: taps ahead of the pointer, still zero
        '{ROW_WRITE,      REG_DELAY_WHOLE,    16'hFFFF,  24'd0,       24'd0},
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     24'h123456,  24'd0},
        '{ROW_WRITE,      REG_DELAY_FRACTION, 16'hFFFF,  24'd0,       24'd0},
        '{ROW_FEED_KNOWN, REG_DELAY_WHOLE,    16'd0,     24'h654321,  24'd0},
        // half-sample interpolation
        '{ROW_WRITE,      REG_DELAY_WHOLE,    16'd1,     24'd0,       24'd0},
        '{ROW_WRITE,      REG_DELAY_FRACTION, 16'd32768, 24'd0,       24'd0},
        '{ROW_FEED,       REG_DELAY_WHOLE,    16'd0,     SMIN,        24'd0},
        // unity feedback drives the ring into saturation
        '{ROW_WRITE,      REG_FEEDBACK_GAIN,  16'd32768, 24'd0,       24'd0},
        '{ROW_WRITE,      REG_DELAY_FRACTION, 16'd0,     24'd0,       24'd0},
        '{ROW_FEED,       REG_DELAY_WHOLE,    16'd0,     SMAX,        24'd0},
        '{ROW_FEED,       REG_DELAY_WHOLE,    16'd0,     SMAX,        24'd0},
        '{ROW_FEED,       REG_DELAY_WHOLE,    16'd0,     SMAX,        24'd0},
        // gain above one is held at one
        '{ROW_WRITE,      REG_FEEDBACK_GAIN,  16'hFFFF,  24'd0,       24'd0},
        '{ROW_FEED,       REG_DELAY_WHOLE,    16'd0,     SMIN,        24'd0},
        '{ROW_FEED,       REG_DELAY_WHOLE,    16'd0,     SMIN,        24'd0},
        '{ROW_FEED,       REG_DELAY_WHOLE,    16'd0,     SMIN,        24'd0},
        // write to the unused index must change nothing
        '{ROW_WRITE,      REG_SPARE,          16'd5,     24'd0,       24'd0},
        '{ROW_FEED,       REG_DELAY_WHOLE,    16'd0,     24'h000100,  24'd0},
        '{ROW_FEED,       REG_DELAY_WHOLE,    16'd0,     NEG1,        24'd0},
        // smallest fraction, floor of a positive step
        '{ROW_WRITE,      REG_DELAY_FRACTION, 16'd1,     24'd0,       24'd0},
        '{ROW_FEED,       REG_DELAY_WHOLE,    16'd0,     24'h400000,  24'd0}
    };

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDW-1:0]         s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDW-1:0]         m_axis_tdata;

    feedback_comb_filter u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #10ms;
        $display("tb_top: errors");
        $finish;
    end

    // Predictor state
    logic signed [SW-1:0]     comb_ring [DEPTH];
    int unsigned              ring_wp;
    logic [DELAY_WHOLE_W-1:0] cur_whole;
    logic [FRACTION_W-1:0]    cur_frac;
    logic [GAIN_W-1:0]        cur_gain;

    logic [SW-1:0] y_expected [$];

    int  n_errors  = 0;
    int  n_fed     = 0;
    int  n_results = 0;
    int  n_writes  = 0;
    int  n_phase   = 0;
    bit  no_idle   = 1'b0;

    // One sample through the comb: returns y, writes x + g*y back into the ring.
    function automatic logic [SW-1:0] comb_predict(input logic [SW-1:0] x_bits);
        int unsigned d, g, a1, a2;
        longint      s1, s2, y, fb, w, x, hi, lo;
        d = 32'(cur_whole);
        if (d < 1) d = 1;
        if (d > DEPTH - 2) d = DEPTH - 2;
        g = 32'(cur_gain);
        if (g > 32'(GAIN_ONE)) g = 32'(GAIN_ONE);
        a1 = (ring_wp + DEPTH - d) % DEPTH;
        a2 = (ring_wp + DEPTH - d - 1) % DEPTH;
        s1 = comb_ring[RAW'(a1)];
        s2 = comb_ring[RAW'(a2)];
        y  = s1 + (((s2 - s1) * longint'(cur_frac)) >>> 16);
        x  = longint'(signed'(x_bits));
        fb = (y * longint'(g)) >>> 15;
        hi = (longint'(1) <<< (SW - 1)) - 1;
        lo = -hi - 1;
        w  = x + fb;
        if (w > hi) w = hi;
        if (w < lo) w = lo;
        comb_ring[RAW'(ring_wp)] = w[SW-1:0];
        ring_wp = (ring_wp + 1) % DEPTH;
        return y[SW-1:0];
    endfunction

    // Offer one sample, with random idle cycles ahead of it; returns at the transfer edge.
    task automatic send_sample(input logic [SW-1:0] x);
        while (!no_idle && $urandom_range(99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDW'(x);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        n_fed++;
        y_expected.push_back(comb_predict(x));
    endtask

    // Drain the pipeline before touching registers.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (y_expected.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        n_writes++;
        case (idx)
            REG_DELAY_WHOLE:    cur_whole = val[DELAY_WHOLE_W-1:0];
            REG_DELAY_FRACTION: cur_frac  = val[FRACTION_W-1:0];
            REG_FEEDBACK_GAIN:  cur_gain  = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // Receiver: random back-pressure, none while no_idle is set, plus one long hold once the ring is busy.
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!hold_done && n_fed >= 250) begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 19);
        end
    end

    always @(posedge aclk) begin : out_check
        logic [SW-1:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (y_expected.size() == 0) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: audio_out expected none, got %h", $time, m_axis_tdata);
            end else begin
                want = y_expected.pop_front();
                if (m_axis_tdata[SW-1:0] !== want) begin
                    n_errors++;
                    if (n_errors <= 40)
                        $display("%0t: audio_out expected %h, got %h",
                                 $time, want, m_axis_tdata[SW-1:0]);
                end
            end
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] v;
        logic [SW-1:0]         x;
        int                    n_items;
        int                    target;

        for (int i = 0; i < DEPTH; i++) comb_ring[RAW'(i)] = '0;
        ring_wp   = 0;
        cur_whole = DELAY_WHOLE_RESET;
        cur_frac  = DELAY_FRACTION_RESET;
        cur_gain  = FEEDBACK_GAIN_RESET;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_ROWS; r++) begin
            case (DIRECTED[r].kind)
                ROW_WRITE: begin
                    settle();
                    write_reg(DIRECTED[r].idx, DIRECTED[r].val);
                end
                ROW_FEED_KNOWN: begin
                    send_sample(DIRECTED[r].sample);
                    // typed value replaces the predicted one
                    void'(y_expected.pop_back());
                    y_expected.push_back(DIRECTED[r].want);
                end
                default: send_sample(DIRECTED[r].sample);
            endcase
        end

        target = n_fed + RANDOM_ITEMS;
        while (n_fed < target) begin
            n_phase++;
            settle();
            no_idle = (n_phase >= 6 && n_phase < 10);

            if ($urandom_range(2) != 0) begin
                case ($urandom_range(9))
                    0:       v = 16'd0;
                    1:       v = 16'd8190;
                    2:       v = 16'd8191 | (16'($urandom_range(7)) << 13);
                    3:       v = 16'($urandom);
                    4, 5:    v = 16'($urandom_range(n_fed + 2, 1));
                    default: v = 16'($urandom_range(24, 1));
                endcase
                write_reg(REG_DELAY_WHOLE, v);
            end
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(9))
                    0:       v = 16'd0;
                    1:       v = 16'hFFFF;
                    2:       v = 16'd32768;
                    default: v = 16'($urandom);
                endcase
                write_reg(REG_DELAY_FRACTION, v);
            end
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(9))
                    0:          v = 16'd0;
                    1:          v = GAIN_ONE;
                    2:          v = 16'($urandom_range(65535, 32769));
                    3, 4, 5:    v = 16'($urandom_range(32768, 24000));
                    default:    v = 16'($urandom_range(32768));
                endcase
                write_reg(REG_FEEDBACK_GAIN, v);
            end
            if ($urandom_range(7) == 0)
                write_reg(REG_SPARE, 16'($urandom));

            n_items = $urandom_range(40, 8);
            for (int k = 0; k < n_items && n_fed < target; k++) begin
                case ($urandom_range(9))
                    0:       x = SMAX;
                    1:       x = SMIN;
                    2:       x = SW'($urandom_range(511)) - SW'(256);
                    default: x = SW'($urandom);
                endcase
                send_sample(x);
            end
        end

        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;
        while (y_expected.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d samples, %0d results, %0d register writes over %0d random phases,",
                 n_fed, n_results, n_writes, n_phase);
        $display("including delay clamps, gain saturation, unused index and a long output stall.");
        if (n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
src/fbcomb_pkg.sv
src/fbcomb_ram.sv
src/fbcomb_ctrl.sv
src/fbcomb_dp.sv
src/feedback_comb_filter.sv
tb/tb_top.sv
